// ----- sv/spl_pkg.sv -----
// ----------------------------------------------------------------------------
// spl_pkg: shared types and constants for the sorted priority list
// Request and status codes, default sizes and the cell-to-cell link types.
// ----------------------------------------------------------------------------
package spl_pkg;

  // Default sizes
  localparam int unsigned SPL_DEPTH     = 64;
  localparam int unsigned SPL_ID_BITS   = 8;
  localparam int unsigned SPL_NICE_BITS = 8;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NOP    = 2'd3
  } spl_req_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } spl_status_e;

  // Ripple link between neighboring cells
  typedef struct packed {
    logic open;  // new entry belongs at or before this cell
    logic seen;  // id match found at or before this cell
  } spl_link_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;   // shift-in insert this cycle
    logic del;   // shift-out delete this cycle
  } spl_op_t;

endpackage

// ----- sv/sorted_priority_list.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_list: sorted list with insert, delete and query
// A row of DEPTH cells kept in nice/flag order with one result per request.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_ready_o is high. Insert, delete
// and query finish in the cycle the transaction is accepted: every cell
// compares its entry with the request at once and sets its own open flag,
// the seen flag ripples down the row of DEPTH cells, and each cell takes
// its own, its left or right neighbor's or the new entry. The result is held
// in an output register and shows up the cycle after acceptance; in_ready_o
// stays high while that register is empty or being taken, so the sustained
// rate is one transaction per cycle. The longest path is the ripple of the
// seen flag through all DEPTH cells into the count and found logic.
module sorted_priority_list
  import spl_pkg::*;
#(
  parameter int unsigned DEPTH     = SPL_DEPTH,
  parameter int unsigned ID_BITS   = SPL_ID_BITS,
  parameter int unsigned NICE_BITS = SPL_NICE_BITS,
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [ID_BITS-1:0]   entry_id_i,
  input  logic [NICE_BITS-1:0] nice_i,
  input  logic                 flag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic                 found_o,
  output logic [CNT_BITS-1:0]  count_o
);

  logic [CNT_BITS-1:0]  count_q, count_d;
  logic                 out_valid_q;
  spl_status_e          status_q, status_d;
  logic                 found_q,  found_d;
  logic                 in_fire;
  logic                 full;
  spl_req_e             req;
  spl_op_t              op;

  spl_link_t            link    [DEPTH+1];
  logic [ID_BITS-1:0]   cell_id   [DEPTH];
  logic [NICE_BITS-1:0] cell_nice [DEPTH];
  logic                 cell_flag [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_BITS'(DEPTH));
  assign req        = spl_req_e'(req_type_i);

  // Command decode
  always_comb begin
    op       = '0;
    status_d = ST_DONE;
    found_d  = 1'b0;
    count_d  = count_q;
    unique case (req)
      REQ_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op.ins  = in_fire;
          count_d = count_q + CNT_BITS'(1);
        end
      end
      REQ_DELETE: begin
        op.del = in_fire;
        if (link[DEPTH].seen) begin
          count_d = count_q - CNT_BITS'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      REQ_QUERY: begin
        found_d = link[DEPTH].seen;
      end
      REQ_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Row of cells
  assign link[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]   l_id,   r_id;
    logic [NICE_BITS-1:0] l_nice, r_nice;
    logic                 l_flag, r_flag;

    if (i == 0) begin : g_first
      assign l_id   = entry_id_i;
      assign l_nice = nice_i;
      assign l_flag = flag_i;
    end else begin : g_mid
      assign l_id   = cell_id[i-1];
      assign l_nice = cell_nice[i-1];
      assign l_flag = cell_flag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_id   = entry_id_i;
      assign r_nice = nice_i;
      assign r_flag = flag_i;
    end else begin : g_inner
      assign r_id   = cell_id[i+1];
      assign r_nice = cell_nice[i+1];
      assign r_flag = cell_flag[i+1];
    end

    spl_cell #(
      .IDX       (i),
      .ID_BITS   (ID_BITS),
      .NICE_BITS (NICE_BITS),
      .CNT_BITS  (CNT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .count_i      (count_q),
      .new_id_i     (entry_id_i),
      .new_nice_i   (nice_i),
      .new_flag_i   (flag_i),
      .left_id_i    (l_id),
      .left_nice_i  (l_nice),
      .left_flag_i  (l_flag),
      .right_id_i   (r_id),
      .right_nice_i (r_nice),
      .right_flag_i (r_flag),
      .link_i       (link[i]),
      .link_o       (link[i+1]),
      .id_o         (cell_id[i]),
      .nice_o       (cell_nice[i]),
      .flag_o       (cell_flag[i])
    );
  end

  // Count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign count_o     = count_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("entry count exceeds depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req == REQ_INSERT && !full) |=> count_q == $past(count_q) + CNT_BITS'(1))
    else $error("insert did not grow the list");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> count_q == CNT_BITS'(DEPTH))
    else $error("full status reported on a list that is not full");

  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(found_q && status_q != ST_DONE))
    else $error("found set together with an error status");

endmodule

// ----- sv/spl_cell.sv -----
// ----------------------------------------------------------------------------
// spl_cell: one position of the sorted list
// Holds one entry, compares it with the request and takes its own entry,
// the left neighbor's, the right neighbor's or the new one.
// ----------------------------------------------------------------------------
module spl_cell
  import spl_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned ID_BITS   = SPL_ID_BITS,
  parameter int unsigned NICE_BITS = SPL_NICE_BITS,
  parameter int unsigned CNT_BITS  = 7
) (
  input  logic                 clk_i,
  input  spl_op_t              op_i,
  input  logic [CNT_BITS-1:0]  count_i,
  input  logic [ID_BITS-1:0]   new_id_i,
  input  logic [NICE_BITS-1:0] new_nice_i,
  input  logic                 new_flag_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  logic [NICE_BITS-1:0] left_nice_i,
  input  logic                 left_flag_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  input  logic [NICE_BITS-1:0] right_nice_i,
  input  logic                 right_flag_i,
  input  spl_link_t            link_i,
  output spl_link_t            link_o,
  output logic [ID_BITS-1:0]   id_o,
  output logic [NICE_BITS-1:0] nice_o,
  output logic                 flag_o
);

  logic [ID_BITS-1:0]   id_q,   id_d;
  logic [NICE_BITS-1:0] nice_q, nice_d;
  logic                 flag_q, flag_d;
  logic                 occ;
  logic                 ahead;

  // Occupancy and key compare
  assign occ   = (CNT_BITS'(IDX) < count_i);
  assign ahead = (new_nice_i < nice_q) ||
                 ((new_nice_i == nice_q) && new_flag_i && !flag_q);

  assign link_o.open = !occ || ahead;
  assign link_o.seen = link_i.seen || (occ && (id_q == new_id_i));

  // Next entry selection
  always_comb begin
    id_d   = id_q;
    nice_d = nice_q;
    flag_d = flag_q;
    if (op_i.ins && link_o.open) begin
      if (link_i.open) begin
        id_d   = left_id_i;
        nice_d = left_nice_i;
        flag_d = left_flag_i;
      end else begin
        id_d   = new_id_i;
        nice_d = new_nice_i;
        flag_d = new_flag_i;
      end
    end else if (op_i.del && link_o.seen) begin
      id_d   = right_id_i;
      nice_d = right_nice_i;
      flag_d = right_flag_i;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    nice_q <= nice_d;
    flag_q <= flag_d;
  end

  assign id_o   = id_q;
  assign nice_o = nice_q;
  assign flag_o = flag_q;

endmodule

// ----- tb/sv/tb_sorted_priority_list.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_priority_list: self-checking bench for the sorted priority list
// Feeds insert, delete, query and no-op requests with random gaps on both
// channels and checks every result against a behavioral list kept alongside.
// ----------------------------------------------------------------------------
module tb_sorted_priority_list;
  import spl_pkg::*;

  localparam int unsigned DEPTH     = SPL_DEPTH;
  localparam int unsigned ID_W      = SPL_ID_BITS;
  localparam int unsigned NICE_W    = SPL_NICE_BITS;
  localparam int unsigned CNT_W     = $clog2(SPL_DEPTH + 1);
  localparam int unsigned N_REQS    = 550;
  localparam int unsigned MAX_CYC   = 200000;
  localparam int unsigned MAX_PRINT = 40;

  // One request as driven on the input channel
  typedef struct {
    spl_req_e          req;
    logic [ID_W-1:0]   id;
    logic [NICE_W-1:0] nice;
    logic              flag;
  } list_req_t;

  // One held list entry
  typedef struct {
    logic [ID_W-1:0]   id;
    logic [NICE_W-1:0] nice;
    logic              flag;
  } list_entry_t;

  // One expected result
  typedef struct {
    spl_status_e       status;
    logic              found;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i   = 2'd0;
  logic [ID_W-1:0]     entry_id_i   = '0;
  logic [NICE_W-1:0]   nice_i       = '0;
  logic                flag_i       = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [1:0]          status_o;
  logic                found_o;
  logic [CNT_W-1:0]    count_o;

  list_req_t           pending_q[$];
  list_result_t        result_q[$];
  list_entry_t         held_q[$];
  int                  gen_ids[$];

  list_req_t           drv_item;
  list_result_t        want;
  logic                in_taken     = 1'b0;
  logic                out_taken    = 1'b0;
  int unsigned         send_wait    = 0;
  int unsigned         recv_wait    = 0;
  int unsigned         cycle_cnt    = 0;
  int unsigned         total_reqs   = 0;
  int unsigned         accepted_cnt = 0;
  int unsigned         checked_cnt  = 0;
  int unsigned         err_cnt      = 0;
  int unsigned         n_ins, n_del, n_qry, n_nop, n_full, n_miss, n_hit, peak_fill;

  sorted_priority_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .entry_id_i  (entry_id_i),
    .nice_i      (nice_i),
    .flag_i      (flag_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .found_o     (found_o),
    .count_o     (count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mismatch reporting: one line each, printing capped, all counted
  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINT) $display("mismatch @cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Idle draw; one stretch of the run in every three has no idling
  function automatic int unsigned draw_wait();
    if (((cycle_cnt / 256) % 3) == 2) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Apply one request to the behavioral list and return its result
  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    list_entry_t  e;
    int           pos;
    res.status = ST_DONE;
    res.found  = 1'b0;
    pos        = -1;
    case (r.req)
      REQ_INSERT: begin
        n_ins++;
        if (held_q.size() >= DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          e.id   = r.id;
          e.nice = r.nice;
          e.flag = r.flag;
          // new entry goes after everything that ties with it
          pos = held_q.size();
          for (int i = 0; i < held_q.size(); i++) begin
            if (r.nice < held_q[i].nice ||
                (r.nice == held_q[i].nice && r.flag > held_q[i].flag)) begin
              pos = i;
              break;
            end
          end
          held_q.insert(pos, e);
          if (held_q.size() > peak_fill) peak_fill = held_q.size();
        end
      end
      REQ_DELETE: begin
        n_del++;
        for (int i = 0; i < held_q.size(); i++) begin
          if (held_q[i].id == r.id) begin
            pos = i;
            break;
          end
        end
        if (pos < 0) begin
          res.status = ST_NOT_FOUND;
          n_miss++;
        end else begin
          held_q.delete(pos);
        end
      end
      REQ_QUERY: begin
        n_qry++;
        foreach (held_q[i]) if (held_q[i].id == r.id) res.found = 1'b1;
        if (res.found) n_hit++;
      end
      default: n_nop++;
    endcase
    res.count = CNT_W'(held_q.size());
    return res;
  endfunction

  // Stimulus helpers: queue a request and track which ids will be held
  task automatic push_request(input spl_req_e req, input int id, input int nice,
                              input logic flag);
    list_req_t r;
    r.req  = req;
    r.id   = ID_W'(id);
    r.nice = NICE_W'(nice);
    r.flag = flag;
    pending_q.push_back(r);
    if (req != REQ_NOP) total_reqs++;
    if (req == REQ_INSERT && gen_ids.size() < DEPTH) gen_ids.push_back(id);
    if (req == REQ_DELETE) begin
      foreach (gen_ids[i]) begin
        if (gen_ids[i] == id) begin
          gen_ids.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic int pick_id();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_nice();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2, 3:    return $urandom_range(0, 3);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_held_id(input int pct);
    if (gen_ids.size() != 0 && $urandom_range(0, 99) < pct)
      return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
    return pick_id();
  endfunction

  task automatic push_random(input int ins_pct, input int del_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3)
      push_request(REQ_NOP, $urandom_range(0, 255), $urandom_range(0, 255),
                   1'($urandom_range(0, 1)));
    else if (sel < 3 + ins_pct)
      push_request(REQ_INSERT, pick_id(), pick_nice(), 1'($urandom_range(0, 1)));
    else if (sel < 3 + ins_pct + del_pct)
      push_request(REQ_DELETE, pick_held_id(80), $urandom_range(0, 255),
                   1'($urandom_range(0, 1)));
    else
      push_request(REQ_QUERY, pick_held_id(60), $urandom_range(0, 255),
                   1'($urandom_range(0, 1)));
  endtask

  // Input driver: pops pending requests, random gap after each
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_wait != 0) begin
        send_wait  <= send_wait - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        drv_item    = pending_q.pop_front();
        req_type_i <= drv_item.req;
        entry_id_i <= drv_item.id;
        nice_i     <= drv_item.nice;
        flag_i     <= drv_item.flag;
        in_valid_i <= 1'b1;
        send_wait  <= draw_wait();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver: random stall after each result taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_taken) recv_wait = draw_wait();
      if (recv_wait != 0) begin
        out_ready_i <= 1'b0;
        if (out_valid_o) recv_wait = recv_wait - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on each request transaction, check each result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        result_q.push_back(apply_request('{spl_req_e'(req_type_i), entry_id_i,
                                           nice_i, flag_i}));
        if (spl_req_e'(req_type_i) != REQ_NOP) accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = result_q.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      checked_cnt, status_o, want.status));
          if (found_o !== want.found)
            report_mismatch($sformatf("result %0d: found %0b, expected %0b",
                                      checked_cnt, found_o, want.found));
          if (count_o !== want.count)
            report_mismatch($sformatf("result %0d: count %0d, expected %0d",
                                      checked_cnt, count_o, want.count));
          checked_cnt++;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYC) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int phase;

    // Directed: empty list, extremes, ties, duplicate ids, no-ops
    push_request(REQ_QUERY,  0,    0,    1'b0);
    push_request(REQ_DELETE, 255,  255,  1'b1);
    push_request(REQ_NOP,    255,  255,  1'b1);
    push_request(REQ_INSERT, 0,    0,    1'b0);
    push_request(REQ_INSERT, 255,  255,  1'b1);
    push_request(REQ_INSERT, 8'h55, 255, 1'b0);
    push_request(REQ_INSERT, 8'hAA, 0,   1'b1);
    push_request(REQ_INSERT, 7,    8'h80, 1'b1);
    push_request(REQ_INSERT, 7,    8'h80, 1'b1);
    push_request(REQ_INSERT, 8,    8'h80, 1'b0);
    push_request(REQ_QUERY,  7,    0,    1'b0);
    push_request(REQ_QUERY,  9,    0,    1'b0);
    push_request(REQ_DELETE, 7,    0,    1'b0);
    push_request(REQ_QUERY,  7,    0,    1'b0);
    push_request(REQ_DELETE, 7,    0,    1'b0);
    push_request(REQ_QUERY,  7,    0,    1'b0);
    push_request(REQ_DELETE, 7,    0,    1'b0);
    push_request(REQ_NOP,    0,    0,    1'b0);
    push_request(REQ_DELETE, 255,  0,    1'b0);
    push_request(REQ_DELETE, 0,    0,    1'b0);
    push_request(REQ_QUERY,  8'hAA, 0,   1'b0);

    // Fill to capacity, then inserts into the full list
    while (gen_ids.size() < DEPTH)
      push_request(REQ_INSERT, pick_id(), pick_nice(), 1'($urandom_range(0, 1)));
    repeat (3) push_request(REQ_INSERT, pick_id(), pick_nice(), 1'($urandom_range(0, 1)));
    push_request(REQ_QUERY, pick_held_id(100), 0, 1'b0);
    push_request(REQ_DELETE, pick_held_id(100), 0, 1'b0);

    // Random phases: fill-heavy, drain-heavy, mixed
    phase = 0;
    while (total_reqs < N_REQS) begin
      repeat (40) begin
        case (phase % 3)
          0:       push_random(80, 10);
          1:       push_random(15, 65);
          default: push_random(40, 35);
        endcase
      end
      phase++;
    end

    n_ins = 0; n_del = 0; n_qry = 0; n_nop = 0;
    n_full = 0; n_miss = 0; n_hit = 0; peak_fill = 0;

    // Reset held, then released on a falling edge
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all requests accepted and every result back
    while (accepted_cnt < total_reqs || pending_q.size() != 0 || result_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Ran %0d inserts, %0d deletes, %0d queries, %0d no-ops; full hits %0d,",
             n_ins, n_del, n_qry, n_nop, n_full);
    $display("delete misses %0d, query hits %0d, peak fill %0d, results checked %0d",
             n_miss, n_hit, peak_fill, checked_cnt);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
